/* rtl/core/leib_pkg.sv */
// Package for the line edit input buffer: request and result types, key and
// result codes, ring index helpers. No dependencies.
`default_nettype none
package leib_pkg;

  localparam int RING_DEPTH = 128;
  localparam int IDX_MOD    = 2 * RING_DEPTH;
  localparam int IDX_W      = $clog2(IDX_MOD);
  localparam int ADDR_W     = $clog2(RING_DEPTH);

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [ADDR_W-1:0] addr_t;

  localparam logic [5:0] MAX_READ = 6'd63;

  localparam logic [7:0] KEY_PROC = 8'h10;
  localparam logic [7:0] KEY_KILL = 8'h15;
  localparam logic [7:0] KEY_BS   = 8'h08;
  localparam logic [7:0] KEY_DEL  = 8'h7F;
  localparam logic [7:0] KEY_EOF  = 8'h04;
  localparam logic [7:0] KEY_CR   = 8'h0D;
  localparam logic [7:0] KEY_LF   = 8'h0A;
  localparam logic [7:0] KEY_NONE = 8'h00;

  localparam logic MODE_KEY  = 1'b0;
  localparam logic MODE_READ = 1'b1;

  localparam logic [2:0] KIND_ECHO      = 3'd0;
  localparam logic [2:0] KIND_ERASE     = 3'd1;
  localparam logic [2:0] KIND_READ_BYTE = 3'd2;
  localparam logic [2:0] KIND_READ_END  = 3'd3;
  localparam logic [2:0] KIND_PROC      = 3'd4;

  localparam logic [1:0] END_DONE  = 2'd0;
  localparam logic [1:0] END_EOF   = 2'd1;
  localparam logic [1:0] END_EMPTY = 2'd2;

  typedef struct packed {
    logic       mode;
    logic [7:0] key_code;
    logic [5:0] read_limit;
  } item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data_byte;
    logic [7:0] erase_or_read_count;
    logic       line_ready;
    logic [1:0] end_status;
    logic       last;
  } result_t;

  typedef enum logic [2:0] {
    OP_PROC,
    OP_KILL,
    OP_ERASE,
    OP_STORE,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] key;
    logic [5:0] limit;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_KILL_RD,
    S_KILL_CHK,
    S_RD_CHK,
    S_RD_DAT,
    S_RD_END
  } back_state_t;

  function automatic idx_t idx_inc(input idx_t x);
    return (x == idx_t'(IDX_MOD - 1)) ? '0 : x + idx_t'(1);
  endfunction

  function automatic idx_t idx_dec(input idx_t x);
    return (x == '0) ? idx_t'(IDX_MOD - 1) : x - idx_t'(1);
  endfunction

  function automatic idx_t idx_diff(input idx_t a, input idx_t b);
    return (a >= b) ? a - b : a + idx_t'(IDX_MOD) - b;
  endfunction

  function automatic addr_t slot_of(input idx_t x);
    return (x >= idx_t'(RING_DEPTH)) ? addr_t'(x - idx_t'(RING_DEPTH)) : addr_t'(x);
  endfunction

endpackage
`default_nettype wire

/* rtl/core/line_edit_input_buffer.sv */
// Top level of the canonical-mode console input buffer.
// Instantiates leib_front and leib_back; types from leib_pkg.
//
// A request is taken when start is high and busy is low; busy rises only while
// two requests wait in the queue between front and back end. Results appear
// for one cycle each with result_strobe high and must be taken then. A
// process-listing, erase or stored key gives its one result from the back end's
// result register once its command leaves the queue; a zero key or a key that
// meets a full ring gives none. A kill steps through S_KILL_RD and S_KILL_CHK
// once per erased character and a read through S_RD_CHK and S_RD_DAT once per
// delivered byte, as each ring step waits on the single registered read port.
`default_nettype none
module line_edit_input_buffer (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire leib_pkg::item_t   item,
  output leib_pkg::result_t      result,
  output logic                   result_strobe
);

  logic           cmd_valid;
  leib_pkg::cmd_t cmd;
  logic           cmd_pop;

  leib_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  leib_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop),
    .result        (result),
    .result_strobe (result_strobe)
  );

endmodule
`default_nettype wire

/* rtl/core/leib_front.sv */
// Front end: accepts requests, classifies them into commands and holds them
// in a two-entry queue for the back end. Depends on leib_pkg.
`default_nettype none
module leib_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  output logic                 busy,
  input  wire leib_pkg::item_t item,
  output logic                 cmd_valid,
  output leib_pkg::cmd_t       cmd,
  input  wire logic            cmd_pop
);

  leib_pkg::cmd_t q [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  leib_pkg::cmd_t cmd_in;
  logic           push;

  always_comb begin
    cmd_in.key   = (item.key_code == leib_pkg::KEY_CR) ? leib_pkg::KEY_LF : item.key_code;
    cmd_in.limit = (item.read_limit > leib_pkg::MAX_READ) ? leib_pkg::MAX_READ
                                                          : item.read_limit;
    if (item.mode == leib_pkg::MODE_READ) begin
      cmd_in.op = leib_pkg::OP_READ;
    end else begin
      case (item.key_code)
        leib_pkg::KEY_PROC: cmd_in.op = leib_pkg::OP_PROC;
        leib_pkg::KEY_KILL: cmd_in.op = leib_pkg::OP_KILL;
        leib_pkg::KEY_BS:   cmd_in.op = leib_pkg::OP_ERASE;
        leib_pkg::KEY_DEL:  cmd_in.op = leib_pkg::OP_ERASE;
        default:            cmd_in.op = leib_pkg::OP_STORE;
      endcase
    end
  end

  assign busy      = (count == 2'd2);
  // drop a zero key here: it causes no result
  assign push      = start && !busy &&
                     !(item.mode == leib_pkg::MODE_KEY && item.key_code == leib_pkg::KEY_NONE);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, cmd_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/core/leib_back.sv */
// Back end: owns the byte ring and the read, commit and edit indices and
// carries out queued commands, one result per cycle at most. Depends on leib_pkg.
`default_nettype none
module leib_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cmd_valid,
  input  wire leib_pkg::cmd_t  cmd,
  output logic                 cmd_pop,
  output leib_pkg::result_t    result,
  output logic                 result_strobe
);

  logic [7:0] ring [leib_pkg::RING_DEPTH];
  logic [7:0] rdata;

  leib_pkg::back_state_t state, state_next;
  leib_pkg::idx_t        read_idx, read_idx_next;
  leib_pkg::idx_t        commit_idx, commit_idx_next;
  leib_pkg::idx_t        edit_idx, edit_idx_next;
  leib_pkg::idx_t        erased, erased_next;
  logic [5:0]            taken, taken_next;
  logic [5:0]            limit, limit_next;
  leib_pkg::result_t     result_next;
  logic                  strobe_next;

  logic                  we;
  leib_pkg::addr_t       waddr;
  leib_pkg::addr_t       raddr;
  leib_pkg::idx_t        edit_inc;
  logic                  room;
  logic                  commit_line;

  function automatic leib_pkg::result_t mk_res(input logic [2:0] kind,
                                               input logic [7:0] data,
                                               input logic [7:0] count,
                                               input logic       ready,
                                               input logic [1:0] status,
                                               input logic       last);
    leib_pkg::result_t r;
    r.kind                = kind;
    r.data_byte           = data;
    r.erase_or_read_count = count;
    r.line_ready          = ready;
    r.end_status          = status;
    r.last                = last;
    return r;
  endfunction

  function automatic logic [7:0] sat8(input leib_pkg::idx_t v);
    return (32'(v) > 32'd255) ? 8'hFF : 8'(v);
  endfunction

  assign edit_inc    = leib_pkg::idx_inc(edit_idx);
  assign room        = leib_pkg::idx_diff(edit_idx, read_idx) <
                       leib_pkg::idx_t'(leib_pkg::RING_DEPTH);
  assign commit_line = (cmd.key == leib_pkg::KEY_LF) || (cmd.key == leib_pkg::KEY_EOF) ||
                       (leib_pkg::idx_diff(edit_inc, read_idx) ==
                        leib_pkg::idx_t'(leib_pkg::RING_DEPTH));
  assign waddr       = leib_pkg::slot_of(edit_idx);

  always_comb begin
    state_next      = state;
    read_idx_next   = read_idx;
    commit_idx_next = commit_idx;
    edit_idx_next   = edit_idx;
    erased_next     = erased;
    taken_next      = taken;
    limit_next      = limit;
    result_next     = result;
    strobe_next     = 1'b0;
    cmd_pop         = 1'b0;
    we              = 1'b0;
    raddr           = leib_pkg::slot_of(read_idx);
    case (state)
      leib_pkg::S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          case (cmd.op)
            leib_pkg::OP_PROC: begin
              result_next = mk_res(leib_pkg::KIND_PROC, 8'd0, 8'd0, 1'b0,
                                   leib_pkg::END_DONE, 1'b1);
              strobe_next = 1'b1;
            end
            leib_pkg::OP_KILL: begin
              erased_next = '0;
              state_next  = leib_pkg::S_KILL_RD;
            end
            leib_pkg::OP_ERASE: begin
              if (edit_idx != commit_idx) begin
                edit_idx_next = leib_pkg::idx_dec(edit_idx);
                result_next   = mk_res(leib_pkg::KIND_ERASE, 8'd0, 8'd1, 1'b0,
                                       leib_pkg::END_DONE, 1'b1);
              end else begin
                result_next   = mk_res(leib_pkg::KIND_ERASE, 8'd0, 8'd0, 1'b0,
                                       leib_pkg::END_DONE, 1'b1);
              end
              strobe_next = 1'b1;
            end
            leib_pkg::OP_STORE: begin
              if (room) begin
                we            = 1'b1;
                edit_idx_next = edit_inc;
                if (commit_line) begin
                  commit_idx_next = edit_inc;
                end
                result_next = mk_res(leib_pkg::KIND_ECHO, cmd.key, 8'd0, commit_line,
                                     leib_pkg::END_DONE, 1'b1);
                strobe_next = 1'b1;
              end
            end
            leib_pkg::OP_READ: begin
              taken_next = 6'd0;
              limit_next = cmd.limit;
              state_next = leib_pkg::S_RD_CHK;
            end
            default: ;
          endcase
        end
      end
      leib_pkg::S_KILL_RD: begin
        if (edit_idx == commit_idx) begin
          result_next = mk_res(leib_pkg::KIND_ERASE, 8'd0, sat8(erased), 1'b0,
                               leib_pkg::END_DONE, 1'b1);
          strobe_next = 1'b1;
          state_next  = leib_pkg::S_IDLE;
        end else begin
          raddr      = leib_pkg::slot_of(leib_pkg::idx_dec(edit_idx));
          state_next = leib_pkg::S_KILL_CHK;
        end
      end
      leib_pkg::S_KILL_CHK: begin
        if (rdata == leib_pkg::KEY_LF) begin
          result_next = mk_res(leib_pkg::KIND_ERASE, 8'd0, sat8(erased), 1'b0,
                               leib_pkg::END_DONE, 1'b1);
          strobe_next = 1'b1;
          state_next  = leib_pkg::S_IDLE;
        end else begin
          edit_idx_next = leib_pkg::idx_dec(edit_idx);
          erased_next   = erased + leib_pkg::idx_t'(1);
          state_next    = leib_pkg::S_KILL_RD;
        end
      end
      leib_pkg::S_RD_CHK: begin
        if (taken >= limit) begin
          result_next = mk_res(leib_pkg::KIND_READ_END, 8'd0, 8'(taken), 1'b0,
                               leib_pkg::END_DONE, 1'b1);
          strobe_next = 1'b1;
          state_next  = leib_pkg::S_IDLE;
        end else if (read_idx == commit_idx) begin
          result_next = mk_res(leib_pkg::KIND_READ_END, 8'd0, 8'(taken), 1'b0,
                               leib_pkg::END_EMPTY, 1'b1);
          strobe_next = 1'b1;
          state_next  = leib_pkg::S_IDLE;
        end else begin
          raddr      = leib_pkg::slot_of(read_idx);
          state_next = leib_pkg::S_RD_DAT;
        end
      end
      leib_pkg::S_RD_DAT: begin
        if (rdata == leib_pkg::KEY_EOF) begin
          // consume end of file only when nothing was delivered yet
          if (taken == 6'd0) begin
            read_idx_next = leib_pkg::idx_inc(read_idx);
          end
          result_next = mk_res(leib_pkg::KIND_READ_END, 8'd0, 8'(taken), 1'b0,
                               leib_pkg::END_EOF, 1'b1);
          strobe_next = 1'b1;
          state_next  = leib_pkg::S_IDLE;
        end else begin
          read_idx_next = leib_pkg::idx_inc(read_idx);
          taken_next    = taken + 6'd1;
          result_next   = mk_res(leib_pkg::KIND_READ_BYTE, rdata, 8'd0, 1'b0,
                                 leib_pkg::END_DONE, 1'b0);
          strobe_next   = 1'b1;
          state_next    = (rdata == leib_pkg::KEY_LF) ? leib_pkg::S_RD_END
                                                      : leib_pkg::S_RD_CHK;
        end
      end
      leib_pkg::S_RD_END: begin
        result_next = mk_res(leib_pkg::KIND_READ_END, 8'd0, 8'(taken), 1'b0,
                             leib_pkg::END_DONE, 1'b1);
        strobe_next = 1'b1;
        state_next  = leib_pkg::S_IDLE;
      end
      default: state_next = leib_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      ring[waddr] <= cmd.key;
    end
    rdata <= ring[raddr];
  end

  always_ff @(posedge clk) begin
    erased <= erased_next;
    taken  <= taken_next;
    limit  <= limit_next;
    result <= result_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= leib_pkg::S_IDLE;
      read_idx      <= '0;
      commit_idx    <= '0;
      edit_idx      <= '0;
      result_strobe <= 1'b0;
    end else begin
      state         <= state_next;
      read_idx      <= read_idx_next;
      commit_idx    <= commit_idx_next;
      edit_idx      <= edit_idx_next;
      result_strobe <= strobe_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/leib_check.sv */
// Port-level checker for line_edit_input_buffer, attached by bind.
// Depends on leib_pkg.
`default_nettype none
module leib_check (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              busy,
  input wire leib_pkg::result_t result,
  input wire logic              result_strobe
);

  a_quiet_after_reset: assert property (@(posedge clk) rst |=> !result_strobe && !busy)
    else $error("result or busy right after reset");

  a_byte_not_last: assert property (@(posedge clk) disable iff (rst)
    result_strobe && result.kind == leib_pkg::KIND_READ_BYTE |-> !result.last)
    else $error("read byte marked last");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    result_strobe && (result.kind == leib_pkg::KIND_ECHO ||
                      result.kind == leib_pkg::KIND_ERASE ||
                      result.kind == leib_pkg::KIND_PROC ||
                      result.kind == leib_pkg::KIND_READ_END) |-> result.last)
    else $error("single result not marked last");

  a_status_on_end_only: assert property (@(posedge clk) disable iff (rst)
    result_strobe && result.kind != leib_pkg::KIND_READ_END |-> result.end_status == 2'd0)
    else $error("end status outside read end");

  a_byte_then_more: assert property (@(posedge clk) disable iff (rst)
    result_strobe && result.kind == leib_pkg::KIND_READ_BYTE &&
    result.data_byte == leib_pkg::KEY_LF |=> result_strobe &&
    result.kind == leib_pkg::KIND_READ_END)
    else $error("newline not followed by read end");

endmodule

bind line_edit_input_buffer leib_check u_check (.*);
`default_nettype wire

/* dv/tb_top.sv */
// Self-checking testbench for line_edit_input_buffer: directed and random key and read
// requests, a cycle-free predictor of the ring and its indices, and an in-order result check.
// Depends on leib_pkg and the line_edit_input_buffer RTL only.
`timescale 1ns / 1ps

module tb_top;
  import leib_pkg::*;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  item_t   item = '0;
  logic    busy;
  result_t result;
  logic    result_strobe;

  line_edit_input_buffer u_top (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .item          (item),
    .result        (result),
    .result_strobe (result_strobe)
  );

  always #5 clk = ~clk;

  item_t      req_backlog[$];
  result_t    due_results[$];
  logic [7:0] ring_copy[RING_DEPTH];
  idx_t       rd_ix = '0;
  idx_t       cm_ix = '0;
  idx_t       ed_ix = '0;

  int n_queued = 0;
  int n_counted = 0;
  int n_accepted = 0;
  int n_checked = 0;
  int n_bad = 0;
  int n_ignored = 0;
  int kind_seen[5] = '{default: 0};
  int burst_left = 0;
  int gap_left = 0;

  function automatic void push_result(logic [2:0] kind, logic [7:0] data,
                                      logic [7:0] count, logic ready, logic [1:0] status);
    result_t r;
    r.kind = kind;
    r.data_byte = data;
    r.erase_or_read_count = count;
    r.line_ready = ready;
    r.end_status = status;
    r.last = 1'b0;
    due_results.push_back(r);
  endfunction

  function automatic void edit_line(logic [7:0] key);
    logic [7:0] ch;
    logic [7:0] erased;
    logic       ready;
    erased = '0;
    ch = key;
    if (key == KEY_PROC) begin
      push_result(KIND_PROC, '0, '0, 1'b0, END_DONE);
    end else if (key == KEY_KILL) begin
      while (ed_ix != cm_ix && ring_copy[addr_t'(ed_ix - idx_t'(1))] != KEY_LF) begin
        ed_ix = ed_ix - idx_t'(1);
        erased++;
      end
      push_result(KIND_ERASE, '0, erased, 1'b0, END_DONE);
    end else if (key == KEY_BS || key == KEY_DEL) begin
      if (ed_ix != cm_ix) begin
        ed_ix = ed_ix - idx_t'(1);
        erased = 8'd1;
      end
      push_result(KIND_ERASE, '0, erased, 1'b0, END_DONE);
    end else if (key == KEY_NONE || int'(idx_t'(ed_ix - rd_ix)) >= RING_DEPTH) begin
      n_ignored++;
    end else begin
      if (ch == KEY_CR) ch = KEY_LF;
      ring_copy[addr_t'(ed_ix)] = ch;
      ed_ix = ed_ix + idx_t'(1);
      ready = 1'b0;
      if (ch == KEY_LF || ch == KEY_EOF || int'(idx_t'(ed_ix - rd_ix)) == RING_DEPTH) begin
        cm_ix = ed_ix;
        ready = 1'b1;
      end
      push_result(KIND_ECHO, ch, '0, ready, END_DONE);
    end
  endfunction

  function automatic void deliver_line(logic [5:0] limit);
    logic [5:0] lim;
    logic [7:0] taken;
    logic [1:0] status;
    logic [7:0] ch;
    logic       done;
    lim = (limit > MAX_READ) ? MAX_READ : limit;
    taken = '0;
    status = END_DONE;
    done = 1'b0;
    while (!done && taken < {2'b00, lim}) begin
      if (rd_ix == cm_ix) begin
        status = END_EMPTY;
        done = 1'b1;
      end else begin
        ch = ring_copy[addr_t'(rd_ix)];
        if (ch == KEY_EOF) begin
          if (taken == 0) rd_ix = rd_ix + idx_t'(1);
          status = END_EOF;
          done = 1'b1;
        end else begin
          rd_ix = rd_ix + idx_t'(1);
          push_result(KIND_READ_BYTE, ch, '0, 1'b0, END_DONE);
          taken++;
          if (ch == KEY_LF) done = 1'b1;
        end
      end
    end
    push_result(KIND_READ_END, '0, taken, 1'b0, status);
  endfunction

  function automatic void apply_request(item_t it);
    int      before_n;
    result_t tail;
    before_n = due_results.size();
    if (it.mode == MODE_KEY) edit_line(it.key_code);
    else deliver_line(it.read_limit);
    if (due_results.size() > before_n) begin
      tail = due_results.pop_back();
      tail.last = 1'b1;
      due_results.push_back(tail);
    end
  endfunction

  task automatic queue_key(input logic [7:0] key);
    item_t it;
    it = item_t'($urandom);
    it.mode = MODE_KEY;
    it.key_code = key;
    req_backlog.push_back(it);
    n_queued++;
    if (key != KEY_NONE) n_counted++;
  endtask

  task automatic queue_read(input logic [5:0] limit);
    item_t it;
    it = item_t'($urandom);
    it.mode = MODE_READ;
    it.read_limit = limit;
    req_backlog.push_back(it);
    n_queued++;
    n_counted++;
  endtask

  task automatic queue_line(input int len, input logic [7:0] term);
    int r;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (r < 4) queue_key(KEY_BS);
      else if (r < 7) queue_key(KEY_DEL);
      else if (r < 9) queue_key(KEY_KILL);
      else if (r < 11) queue_key(KEY_PROC);
      else queue_key(8'($urandom_range(32, 126)));
    end
    queue_key(term);
  endtask

  always @(posedge clk) begin : drive
    logic  go;
    item_t nxt;
    go = start;
    nxt = item;
    if (rst) begin
      go = 1'b0;
    end else begin
      if (start && !busy) begin
        apply_request(item);
        n_accepted++;
        go = 1'b0;
      end
      if (!go) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (req_backlog.size() != 0) begin
          nxt = req_backlog.pop_front();
          go = 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
          end
        end
      end
    end
    start <= go;
    item <= nxt;
  end

  always @(posedge clk) begin : watch
    result_t want;
    if (!rst && result_strobe) begin
      if (result.kind <= KIND_PROC) kind_seen[result.kind]++;
      if (due_results.size() == 0) begin
        n_bad++;
        if (n_bad <= 10)
          $display("unexpected result: kind %0d data %02h count %0d", result.kind,
                   result.data_byte, result.erase_or_read_count);
      end else begin
        want = due_results.pop_front();
        n_checked++;
        if (result.kind !== want.kind || result.data_byte !== want.data_byte ||
            result.erase_or_read_count !== want.erase_or_read_count ||
            result.line_ready !== want.line_ready || result.end_status !== want.end_status ||
            result.last !== want.last) begin
          n_bad++;
          if (n_bad <= 10) begin
            $display("mismatch at %0t (exp/got): kind %0d/%0d data %02h/%02h count %0d/%0d",
                     $realtime, want.kind, result.kind, want.data_byte, result.data_byte,
                     want.erase_or_read_count, result.erase_or_read_count);
            $display("  ready %0b/%0b status %0d/%0d last %0b/%0b",
                     want.line_ready, result.line_ready, want.end_status,
                     result.end_status, want.last, result.last);
          end
        end
      end
    end
  end

  initial begin : timeout
    #20_000_000;
    $display("timeout: %0d of %0d requests accepted, %0d results pending",
             n_accepted, n_queued, due_results.size());
    $display("FAIL line_edit_input_buffer");
    $finish;
  end

  initial begin : run
    int r;
    int floods;
    floods = 0;

    queue_read(6'd63);
    queue_read(6'd0);
    queue_key(KEY_BS);
    queue_key(KEY_DEL);
    queue_key(KEY_NONE);
    queue_key(KEY_PROC);
    queue_key(KEY_KILL);
    queue_key(8'h61);
    queue_key(8'hFF);
    queue_key(KEY_CR);
    queue_key(8'h78);
    queue_key(8'h79);
    queue_key(KEY_BS);
    queue_key(8'h7A);
    queue_key(KEY_KILL);
    queue_key(8'h71);
    queue_key(KEY_EOF);
    queue_read(6'd1);
    queue_read(6'd63);
    queue_read(6'd63);
    queue_read(6'd5);
    queue_key(KEY_LF);
    queue_read(6'd63);
    queue_read(6'd63);

    n_counted = 0;
    while (n_counted < 450) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        case ($urandom_range(0, 2))
          0: queue_line($urandom_range(0, 20), KEY_CR);
          1: queue_line($urandom_range(0, 20), KEY_LF);
          default: queue_line($urandom_range(0, 20), KEY_EOF);
        endcase
        if ($urandom_range(0, 3) != 0) queue_read(6'($urandom_range(0, 63)));
      end else if (r < 68) begin
        repeat ($urandom_range(1, 3)) queue_read(6'($urandom_range(0, 63)));
      end else if (r < 85) begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 1) == 0) begin
            queue_key(8'($urandom));
          end else begin
            req_backlog.push_back(item_t'($urandom));
            n_queued++;
            n_counted++;
          end
        end
      end else if (r < 90 && floods < 3) begin
        floods++;
        repeat (RING_DEPTH + 4) queue_key(8'($urandom_range(32, 126)));
        repeat (4) queue_read(MAX_READ);
      end else begin
        repeat ($urandom_range(1, 40)) queue_key(8'($urandom_range(32, 126)));
        queue_key(KEY_KILL);
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (n_accepted != n_queued) @(negedge clk);
    while (due_results.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);

    if (due_results.size() != 0) begin
      $display("%0d expected results never arrived", due_results.size());
      n_bad += due_results.size();
    end
    $display("ran %0d requests (%0d keys ignored), checked %0d results, %0d failures",
             n_accepted, n_ignored, n_checked, n_bad);
    $display("results by kind: echo %0d erase %0d byte %0d read-end %0d proc %0d",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4]);
    if (n_bad == 0) begin
      $display("PASS line_edit_input_buffer");
    end else begin
      $display("FAIL line_edit_input_buffer");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/leib_pkg.sv
rtl/core/leib_front.sv
rtl/core/leib_back.sv
rtl/core/line_edit_input_buffer.sv
rtl/core/leib_check.sv
dv/tb_top.sv
